>>> hw/rtl/pbts_pkg.sv
package pbts_pkg;

  // scheduler dimensions
  localparam int NUM_TASKS      = 16;
  localparam int NUM_PRIORITIES = 32;

  // command codes on in_func
  localparam logic [2:0] FUNC_CREATE  = 3'd0;
  localparam logic [2:0] FUNC_RESUME  = 3'd1;
  localparam logic [2:0] FUNC_SUSPEND = 3'd2;
  localparam logic [2:0] FUNC_SELECT  = 3'd3;
  localparam logic [2:0] FUNC_LOCK    = 3'd4;
  localparam logic [2:0] FUNC_UNLOCK  = 3'd5;

  // per-task state
  localparam logic [1:0] TS_ABSENT = 2'd0;
  localparam logic [1:0] TS_READY  = 2'd1;
  localparam logic [1:0] TS_RUN    = 2'd2;
  localparam logic [1:0] TS_SUSP   = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_IGNORED = 2'd1;
  localparam logic [1:0] ST_NONE    = 2'd2;

  // configuration register indexes
  localparam logic REG_TIME_SLICING = 1'b0;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SEL_HEAD,
    S_UNLINK,
    S_PUSH_RD,
    S_PUSH_WR,
    S_DONE
  } state_t;

endpackage

>>> hw/rtl/pbts_ram.sv
module pbts_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/priority_bitmap_task_scheduler_top.sv
// Channel  | Handshake             | Payload
// ---------+-----------------------+----------------------------------------------
// in_      | in_valid / in_ready   | func, task_id, priority_req
// out_     | out_valid / out_ready | current_task, current_valid, highest_prio,
//          |                       | any_ready, switch_request, status, lock_depth
// cfg      | psel/penable/pwrite   | paddr, pwdata, prdata; pready tied high
//
// One command at a time. Lock, unlock and rejected commands go through decode and
// result; create and resume add a head insert, suspend an unlink, and select
// without slicing a head read. With time slicing, select goes through decode, head
// read, unlink, tail read, tail insert and result; RAM reads are registered.
// rst_n is synchronous; the link and queue end RAMs are not cleared.
// A result held by out_ready low stalls the next command in its final step.
module priority_bitmap_task_scheduler_top (
  input  logic        clk,
  input  logic        rst_n,
  // command channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_func,
  input  logic [3:0]  in_task_id,
  input  logic [7:0]  in_priority_req,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_current_task,
  output logic        out_current_valid,
  output logic [4:0]  out_highest_prio,
  output logic        out_any_ready,
  output logic        out_switch_request,
  output logic [1:0]  out_status,
  output logic [7:0]  out_lock_depth,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int NT = pbts_pkg::NUM_TASKS;
  localparam int NP = pbts_pkg::NUM_PRIORITIES;
  localparam int TW = (NT > 1) ? $clog2(NT) : 1;
  localparam int PW = (NP > 1) ? $clog2(NP) : 1;
  localparam int CW = $clog2(NT + 1);

  pbts_pkg::state_t state_r, state_nxt;

  logic [2:0]    func_r;
  logic [3:0]    id_r;
  logic          id_ok;
  logic [7:0]    preq_r;
  logic [TW-1:0] t_r, t_nxt;
  logic [PW-1:0] p_r, p_nxt;
  logic [1:0]    status_r, status_nxt;
  logic          sw_r, sw_nxt;
  logic          tail_mode_r, tail_mode_nxt;
  logic          ts_r;
  logic [31:0]   bitmap_r, bitmap_nxt;
  logic [3:0]    run_task_r, run_task_nxt;
  logic          run_valid_r, run_valid_nxt;
  logic [7:0]    lock_r, lock_nxt;

  logic [1:0]    task_status_r [NT];
  logic [1:0]    task_status_nxt [NT];
  logic [PW-1:0] task_prio_r [NT];
  logic [PW-1:0] task_prio_nxt [NT];
  logic [CW-1:0] qcount_r [NP];
  logic [CW-1:0] qcount_nxt [NP];

  logic          out_valid_r, out_valid_nxt;
  logic [3:0]    out_task_r;
  logic          out_cvalid_r;
  logic [4:0]    out_top_r;
  logic          out_any_r;
  logic          out_sw_r;
  logic [1:0]    out_status_r;
  logic [7:0]    out_lock_r;
  logic          out_load;

  // RAM ports
  logic          nx_we, pv_we, hd_we, tl_we;
  logic [TW-1:0] nx_waddr, pv_waddr, nx_wdata, pv_wdata, hd_wdata, tl_wdata;
  logic [PW-1:0] hd_waddr, tl_waddr, hd_raddr, tl_raddr;
  logic [TW-1:0] nx_raddr, pv_raddr;
  logic [TW-1:0] nx_rdata, pv_rdata, hd_rdata, tl_rdata;

  logic [4:0]    lz;
  logic          lz_found;
  logic [PW-1:0] clamp_prio;
  logic          cfg_wr;

  // leading-zero count of the ready bitmap: top ready priority
  always_comb begin
    lz = 5'd0;
    lz_found = 1'b0;
    for (int i = 31; i >= 0; i--) begin
      if (!lz_found && bitmap_r[i]) begin
        lz = 5'(31 - i);
        lz_found = 1'b1;
      end
    end
  end

  assign clamp_prio = (int'(preq_r) >= NP) ? PW'(NP - 1) : PW'(preq_r);
  assign id_ok = (int'(id_r) < NT);

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == pbts_pkg::REG_TIME_SLICING);
  assign prdata = {31'd0, ts_r};

  assign in_ready = (state_r == pbts_pkg::S_IDLE);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pbts_pkg::S_IDLE: begin
        if (in_valid) state_nxt = pbts_pkg::S_DECODE;
      end
      pbts_pkg::S_DECODE: begin
        state_nxt = pbts_pkg::S_DONE;
        unique case (func_r)
          pbts_pkg::FUNC_CREATE: begin
            if (id_ok && task_status_r[t_r] == pbts_pkg::TS_ABSENT)
              state_nxt = pbts_pkg::S_PUSH_WR;
          end
          pbts_pkg::FUNC_RESUME: begin
            if (id_ok && task_status_r[t_r] == pbts_pkg::TS_SUSP)
              state_nxt = pbts_pkg::S_PUSH_WR;
          end
          pbts_pkg::FUNC_SUSPEND: begin
            if (id_ok && (task_status_r[t_r] == pbts_pkg::TS_READY ||
                          task_status_r[t_r] == pbts_pkg::TS_RUN))
              state_nxt = pbts_pkg::S_UNLINK;
          end
          pbts_pkg::FUNC_SELECT: begin
            if (bitmap_r != 32'd0 && qcount_r[PW'(lz)] != '0)
              state_nxt = pbts_pkg::S_SEL_HEAD;
          end
          default: state_nxt = pbts_pkg::S_DONE;
        endcase
      end
      pbts_pkg::S_SEL_HEAD: state_nxt = ts_r ? pbts_pkg::S_UNLINK : pbts_pkg::S_DONE;
      pbts_pkg::S_UNLINK: begin
        state_nxt = (func_r == pbts_pkg::FUNC_SELECT) ? pbts_pkg::S_PUSH_RD
                                                      : pbts_pkg::S_DONE;
      end
      pbts_pkg::S_PUSH_RD: state_nxt = pbts_pkg::S_PUSH_WR;
      pbts_pkg::S_PUSH_WR: state_nxt = pbts_pkg::S_DONE;
      pbts_pkg::S_DONE: begin
        if (!out_valid_r || out_ready) state_nxt = pbts_pkg::S_IDLE;
      end
      default: state_nxt = pbts_pkg::S_IDLE;
    endcase
  end

  // datapath and RAM control
  always_comb begin
    logic [CW-1:0] c;
    logic [CW-1:0] newc;
    c = qcount_r[p_r];
    newc = c;
    t_nxt = t_r;
    p_nxt = p_r;
    status_nxt = status_r;
    sw_nxt = sw_r;
    tail_mode_nxt = tail_mode_r;
    bitmap_nxt = bitmap_r;
    run_task_nxt = run_task_r;
    run_valid_nxt = run_valid_r;
    lock_nxt = lock_r;
    task_status_nxt = task_status_r;
    task_prio_nxt = task_prio_r;
    qcount_nxt = qcount_r;
    nx_we = 1'b0; pv_we = 1'b0; hd_we = 1'b0; tl_we = 1'b0;
    nx_waddr = t_r; nx_wdata = t_r;
    pv_waddr = t_r; pv_wdata = t_r;
    hd_waddr = p_r; hd_wdata = t_r;
    tl_waddr = p_r; tl_wdata = t_r;
    nx_raddr = t_r; pv_raddr = t_r;
    hd_raddr = p_r; tl_raddr = p_r;
    out_load = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;

    unique case (state_r)
      pbts_pkg::S_IDLE: begin
        if (in_valid) begin
          t_nxt = TW'(in_task_id);
          status_nxt = pbts_pkg::ST_OK;
          sw_nxt = 1'b0;
          tail_mode_nxt = 1'b0;
        end
      end
      pbts_pkg::S_DECODE: begin
        unique case (func_r)
          pbts_pkg::FUNC_CREATE: begin
            if (!id_ok || task_status_r[t_r] != pbts_pkg::TS_ABSENT) begin
              status_nxt = pbts_pkg::ST_IGNORED;
            end else begin
              task_prio_nxt[t_r] = clamp_prio;
              p_nxt = clamp_prio;
              hd_raddr = clamp_prio;
            end
          end
          pbts_pkg::FUNC_RESUME: begin
            if (!id_ok || task_status_r[t_r] != pbts_pkg::TS_SUSP) begin
              status_nxt = pbts_pkg::ST_IGNORED;
            end else begin
              p_nxt = task_prio_r[t_r];
              hd_raddr = task_prio_r[t_r];
              sw_nxt = 1'b1;
            end
          end
          pbts_pkg::FUNC_SUSPEND: begin
            if (!id_ok || (task_status_r[t_r] != pbts_pkg::TS_READY &&
                           task_status_r[t_r] != pbts_pkg::TS_RUN)) begin
              status_nxt = pbts_pkg::ST_IGNORED;
            end else begin
              sw_nxt = (task_status_r[t_r] == pbts_pkg::TS_RUN);
              p_nxt = task_prio_r[t_r];
              hd_raddr = task_prio_r[t_r];
              tl_raddr = task_prio_r[t_r];
            end
          end
          pbts_pkg::FUNC_SELECT: begin
            if (bitmap_r == 32'd0 || qcount_r[PW'(lz)] == '0) begin
              status_nxt = pbts_pkg::ST_NONE;
            end else begin
              p_nxt = PW'(lz);
              hd_raddr = PW'(lz);
            end
          end
          pbts_pkg::FUNC_LOCK: begin
            if (lock_r != 8'hff) lock_nxt = lock_r + 8'd1;
          end
          pbts_pkg::FUNC_UNLOCK: begin
            if (lock_r != 8'd0) lock_nxt = lock_r - 8'd1;
            if (bitmap_r != 32'd0 &&
                (!run_valid_r || lz < 5'(task_prio_r[TW'(run_task_r)])))
              sw_nxt = 1'b1;
          end
          default: status_nxt = pbts_pkg::ST_IGNORED;
        endcase
      end
      pbts_pkg::S_SEL_HEAD: begin
        // head of the top queue is the chosen task
        if (!ts_r) begin
          task_status_nxt[hd_rdata] = pbts_pkg::TS_RUN;
          run_task_nxt = 4'(hd_rdata);
          run_valid_nxt = 1'b1;
        end else begin
          if (run_valid_r && task_status_r[TW'(run_task_r)] == pbts_pkg::TS_RUN)
            task_status_nxt[TW'(run_task_r)] = pbts_pkg::TS_READY;
          t_nxt = hd_rdata;
          nx_raddr = hd_rdata;
          pv_raddr = hd_rdata;
        end
      end
      pbts_pkg::S_UNLINK: begin
        if (c == CW'(1)) begin
          newc = '0;
        end else if (c != '0) begin
          newc = c - CW'(1);
          if (hd_rdata == t_r) begin
            hd_we = 1'b1; hd_wdata = nx_rdata;
          end else begin
            nx_we = 1'b1; nx_waddr = pv_rdata; nx_wdata = nx_rdata;
          end
          if (tl_rdata == t_r) begin
            tl_we = 1'b1; tl_wdata = pv_rdata;
          end else begin
            pv_we = 1'b1; pv_waddr = nx_rdata; pv_wdata = pv_rdata;
          end
        end
        qcount_nxt[p_r] = newc;
        if (func_r != pbts_pkg::FUNC_SELECT) begin
          if (!ts_r || newc == '0) bitmap_nxt[5'(31) - 5'(p_r)] = 1'b0;
          task_status_nxt[t_r] = pbts_pkg::TS_SUSP;
        end
      end
      pbts_pkg::S_PUSH_RD: begin
        tail_mode_nxt = 1'b1;
      end
      pbts_pkg::S_PUSH_WR: begin
        qcount_nxt[p_r] = c + CW'(1);
        if (c == '0) begin
          hd_we = 1'b1;
          tl_we = 1'b1;
        end else if (!tail_mode_r) begin
          nx_we = 1'b1; nx_waddr = t_r; nx_wdata = hd_rdata;
          pv_we = 1'b1; pv_waddr = hd_rdata; pv_wdata = t_r;
          hd_we = 1'b1;
        end else begin
          pv_we = 1'b1; pv_waddr = t_r; pv_wdata = tl_rdata;
          nx_we = 1'b1; nx_waddr = tl_rdata; nx_wdata = t_r;
          tl_we = 1'b1;
        end
        if (!tail_mode_r) begin
          task_status_nxt[t_r] = pbts_pkg::TS_READY;
          bitmap_nxt[5'(31) - 5'(p_r)] = 1'b1;
        end else begin
          task_status_nxt[t_r] = pbts_pkg::TS_RUN;
          run_task_nxt = 4'(t_r);
          run_valid_nxt = 1'b1;
        end
      end
      pbts_pkg::S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_load = 1'b1;
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pbts_pkg::S_IDLE;
      ts_r <= 1'b1;
      bitmap_r <= 32'd0;
      run_task_r <= 4'd0;
      run_valid_r <= 1'b0;
      lock_r <= 8'd0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NT; i++) begin
        task_status_r[i] <= pbts_pkg::TS_ABSENT;
        task_prio_r[i] <= '0;
      end
      for (int i = 0; i < NP; i++) begin
        qcount_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_wr) ts_r <= pwdata[0];
      bitmap_r <= bitmap_nxt;
      run_task_r <= run_task_nxt;
      run_valid_r <= run_valid_nxt;
      lock_r <= lock_nxt;
      out_valid_r <= out_valid_nxt;
      task_status_r <= task_status_nxt;
      task_prio_r <= task_prio_nxt;
      qcount_r <= qcount_nxt;
    end
  end

  // command and result payload
  always_ff @(posedge clk) begin
    if (state_r == pbts_pkg::S_IDLE && in_valid) begin
      func_r <= in_func;
      id_r <= in_task_id;
      preq_r <= in_priority_req;
    end
    t_r <= t_nxt;
    p_r <= p_nxt;
    status_r <= status_nxt;
    sw_r <= sw_nxt;
    tail_mode_r <= tail_mode_nxt;
    if (out_load) begin
      out_task_r <= run_task_r;
      out_cvalid_r <= run_valid_r;
      out_top_r <= lz;
      out_any_r <= (bitmap_r != 32'd0);
      out_sw_r <= sw_r;
      out_status_r <= status_r;
      out_lock_r <= lock_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_current_task   = out_task_r;
  assign out_current_valid  = out_cvalid_r;
  assign out_highest_prio   = out_top_r;
  assign out_any_ready      = out_any_r;
  assign out_switch_request = out_sw_r;
  assign out_status         = out_status_r;
  assign out_lock_depth     = out_lock_r;

  // link and queue end memories
  pbts_ram #(.WIDTH(TW), .DEPTH(NT)) u_next_ram (
    .clk(clk), .we(nx_we), .waddr(nx_waddr), .wdata(nx_wdata),
    .raddr(nx_raddr), .rdata(nx_rdata)
  );

  pbts_ram #(.WIDTH(TW), .DEPTH(NT)) u_prev_ram (
    .clk(clk), .we(pv_we), .waddr(pv_waddr), .wdata(pv_wdata),
    .raddr(pv_raddr), .rdata(pv_rdata)
  );

  pbts_ram #(.WIDTH(TW), .DEPTH(NP)) u_head_ram (
    .clk(clk), .we(hd_we), .waddr(hd_waddr), .wdata(hd_wdata),
    .raddr(hd_raddr), .rdata(hd_rdata)
  );

  pbts_ram #(.WIDTH(TW), .DEPTH(NP)) u_tail_ram (
    .clk(clk), .we(tl_we), .waddr(tl_waddr), .wdata(tl_wdata),
    .raddr(tl_raddr), .rdata(tl_rdata)
  );

endmodule

>>> hw/rtl/pbts_checker.sv
module pbts_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  out_current_task,
  input logic        out_current_valid,
  input logic [4:0]  out_highest_prio,
  input logic        out_any_ready,
  input logic        out_switch_request,
  input logic [1:0]  out_status,
  input logic [7:0]  out_lock_depth
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
    $stable(out_current_task) && $stable(out_lock_depth))
    else $error("stalled result changed");

  // only three status codes exist
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != 2'd3)
    else $error("undefined status code");

  // a switch is only requested by a command that succeeded
  a_switch_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_switch_request |-> out_status == pbts_pkg::ST_OK)
    else $error("switch request on failed command");

  // an empty bitmap reports top priority zero
  a_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_any_ready |-> out_highest_prio == 5'd0)
    else $error("top priority without ready task");

  // nothing ready is reported only with an empty bitmap
  a_none_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == pbts_pkg::ST_NONE |-> !out_any_ready)
    else $error("nothing ready while bitmap set");

endmodule

bind priority_bitmap_task_scheduler_top pbts_checker u_pbts_checker (.*);

>>> dv/priority_bitmap_task_scheduler_checker.sv
module priority_bitmap_task_scheduler_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [2:0]  in_func,
  input  logic [3:0]  in_task_id,
  input  logic [7:0]  in_priority_req,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [3:0]  out_current_task,
  input  logic        out_current_valid,
  input  logic [4:0]  out_highest_prio,
  input  logic        out_any_ready,
  input  logic        out_switch_request,
  input  logic [1:0]  out_status,
  input  logic [7:0]  out_lock_depth,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [3:0] cur_task;
    logic       cur_valid;
    logic [4:0] top_prio;
    logic       any_rdy;
    logic       sw_req;
    logic [1:0] status;
    logic [7:0] depth;
  } sched_result_t;

  // scheduler shadow state
  logic [1:0]  t_state [16];
  logic [4:0]  t_prio  [16];
  logic [3:0]  nxt     [16];
  logic [3:0]  prv     [16];
  logic [3:0]  q_head  [32];
  logic [3:0]  q_tail  [32];
  logic [4:0]  q_cnt   [32];
  logic [31:0] bitmap;
  logic [3:0]  run_id;
  logic        run_ok;
  logic [7:0]  locks;
  logic        slicing;

  sched_result_t expected_results[$];

  function automatic logic [5:0] lzc(logic [31:0] v);
    logic [5:0] n;
    n = 0;
    while (n < 32 && !v[31 - n]) n++;
    return n;
  endfunction

  function automatic logic [31:0] pbit(logic [4:0] p);
    return 32'h8000_0000 >> p;
  endfunction

  function automatic void unlink_task(logic [3:0] t);
    logic [4:0] p;
    p = t_prio[t];
    if (q_cnt[p] == 0) return;
    if (q_cnt[p] == 1) begin
      q_cnt[p] = 0;
      return;
    end
    if (q_head[p] == t) q_head[p] = nxt[t];
    else nxt[prv[t]] = nxt[t];
    if (q_tail[p] == t) q_tail[p] = prv[t];
    else prv[nxt[t]] = prv[t];
    q_cnt[p]--;
  endfunction

  function automatic void push_task(logic [3:0] t, logic at_tail);
    logic [4:0] p;
    p = t_prio[t];
    if (q_cnt[p] == 0) begin
      q_head[p] = t;
      q_tail[p] = t;
    end else if (at_tail) begin
      prv[t] = q_tail[p];
      nxt[q_tail[p]] = t;
      q_tail[p] = t;
    end else begin
      nxt[t] = q_head[p];
      prv[q_head[p]] = t;
      q_head[p] = t;
    end
    q_cnt[p]++;
  endfunction

  function automatic void ready_task(logic [3:0] t);
    t_state[t] = pbts_pkg::TS_READY;
    push_task(t, 1'b0);
    bitmap |= pbit(t_prio[t]);
  endfunction

  // one command through the scheduler shadow
  function automatic sched_result_t schedule_cmd(logic [2:0] f, logic [3:0] t,
                                                 logic [7:0] pr);
    sched_result_t r;
    logic [5:0] top;
    logic [3:0] nt;
    r = '0;
    case (f)
      pbts_pkg::FUNC_CREATE: begin
        if (t_state[t] != pbts_pkg::TS_ABSENT) r.status = pbts_pkg::ST_IGNORED;
        else begin
          t_prio[t] = (pr >= 32) ? 5'd31 : pr[4:0];
          ready_task(t);
        end
      end
      pbts_pkg::FUNC_RESUME: begin
        if (t_state[t] != pbts_pkg::TS_SUSP) r.status = pbts_pkg::ST_IGNORED;
        else begin
          ready_task(t);
          r.sw_req = 1'b1;
        end
      end
      pbts_pkg::FUNC_SUSPEND: begin
        if (t_state[t] != pbts_pkg::TS_READY && t_state[t] != pbts_pkg::TS_RUN)
          r.status = pbts_pkg::ST_IGNORED;
        else begin
          if (t_state[t] == pbts_pkg::TS_RUN) r.sw_req = 1'b1;
          unlink_task(t);
          if (!slicing || q_cnt[t_prio[t]] == 0) bitmap &= ~pbit(t_prio[t]);
          t_state[t] = pbts_pkg::TS_SUSP;
        end
      end
      pbts_pkg::FUNC_SELECT: begin
        top = lzc(bitmap);
        if (bitmap == 0 || q_cnt[top[4:0]] == 0) r.status = pbts_pkg::ST_NONE;
        else begin
          nt = q_head[top[4:0]];
          if (slicing) begin
            if (run_ok && t_state[run_id] == pbts_pkg::TS_RUN)
              t_state[run_id] = pbts_pkg::TS_READY;
            unlink_task(nt);
            push_task(nt, 1'b1);
          end
          t_state[nt] = pbts_pkg::TS_RUN;
          run_id = nt;
          run_ok = 1'b1;
        end
      end
      pbts_pkg::FUNC_LOCK: if (locks != 8'hff) locks++;
      pbts_pkg::FUNC_UNLOCK: begin
        if (locks != 0) locks--;
        if (bitmap != 0 && (!run_ok || lzc(bitmap) < t_prio[run_id])) r.sw_req = 1'b1;
      end
      default: r.status = pbts_pkg::ST_IGNORED;
    endcase
    r.cur_task  = run_id;
    r.cur_valid = run_ok;
    r.top_prio  = (bitmap != 0) ? 5'(lzc(bitmap)) : 5'd0;
    r.any_rdy   = (bitmap != 0);
    r.depth     = locks;
    return r;
  endfunction

  always @(posedge clk) begin
    sched_result_t got, want;
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) begin
        t_state[i] = pbts_pkg::TS_ABSENT;
        t_prio[i] = 0;
        nxt[i] = 0;
        prv[i] = 0;
      end
      for (int i = 0; i < 32; i++) begin
        q_cnt[i] = 0;
        q_head[i] = 0;
        q_tail[i] = 0;
      end
      bitmap = 0;
      run_id = 0;
      run_ok = 0;
      locks = 0;
      slicing = 1;
      expected_results.delete();
    end else begin
      // register write
      if (psel && penable && pwrite && pready &&
          paddr == 3'(pbts_pkg::REG_TIME_SLICING) << 2)
        slicing = pwdata[0];
      // accepted request
      if (in_valid && in_ready)
        expected_results.push_back(schedule_cmd(in_func, in_task_id, in_priority_req));
      // accepted result
      if (out_valid && out_ready) begin
        got = '{out_current_task, out_current_valid, out_highest_prio, out_any_ready,
                out_switch_request, out_status, out_lock_depth};
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %p", $realtime, got);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (got.cur_task !== want.cur_task || got.cur_valid !== want.cur_valid ||
              got.top_prio !== want.top_prio || got.any_rdy !== want.any_rdy ||
              got.sw_req !== want.sw_req || got.status !== want.status ||
              got.depth !== want.depth) begin
            $display("%0t: mismatch expected %p actual %p", $realtime, want, got);
            fail_count++;
          end
        end
      end
    end
    pending = expected_results.size();
  end

endmodule

>>> dv/priority_bitmap_task_scheduler_top_test.sv
module priority_bitmap_task_scheduler_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_ready;
  logic [2:0]  in_func = 0;
  logic [3:0]  in_task_id = 0;
  logic [7:0]  in_priority_req = 0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [3:0]  out_current_task;
  logic        out_current_valid;
  logic [4:0]  out_highest_prio;
  logic        out_any_ready;
  logic        out_switch_request;
  logic [1:0]  out_status;
  logic [7:0]  out_lock_depth;
  logic        psel = 0;
  logic        penable = 0;
  logic        pwrite = 0;
  logic [2:0]  paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count;
  int          pending;
  int          cycles = 0;
  int          sent = 0;

  always #2 clk = ~clk;

  priority_bitmap_task_scheduler_top i_dut (.*);

  priority_bitmap_task_scheduler_checker i_checker (.*);

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // result side: random stalls, one long hold-off, one stretch without stalls
  initial begin
    int n;
    n = 0;
    forever begin
      @(posedge clk);
      n++;
      if (n >= 3000 && n < 3300) out_ready <= 1'b0;
      else if (n >= 5000 && n < 7000) out_ready <= 1'b1;
      else out_ready <= ($urandom_range(99) >= 30);
    end
  end

  task automatic send_cmd(logic [2:0] f, logic [3:0] t, logic [7:0] pr);
    logic rdy;
    // no idling for items 400..599
    if (sent < 400 || sent >= 600)
      while ($urandom_range(99) < 30) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    in_valid <= 1'b1;
    in_func <= f;
    in_task_id <= t;
    in_priority_req <= pr;
    forever begin
      @(negedge clk);
      rdy = in_ready;
      @(posedge clk);
      if (rdy) break;
    end
    sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_slicing(logic en);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= 3'(pbts_pkg::REG_TIME_SLICING) << 2;
    pwdata <= {{31{1'($urandom_range(1))}}, en};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  initial begin
    int k;
    logic [2:0] f;
    logic [7:0] pr;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_slicing(1'b1);

    // directed: empty select, unlock at zero, clamping, rejects, unknown codes
    send_cmd(pbts_pkg::FUNC_SELECT, 0, 0);
    send_cmd(pbts_pkg::FUNC_UNLOCK, 0, 0);
    send_cmd(pbts_pkg::FUNC_SUSPEND, 4'hf, 0);
    send_cmd(pbts_pkg::FUNC_RESUME, 4'h0, 0);
    send_cmd(pbts_pkg::FUNC_CREATE, 4'h0, 8'd0);
    send_cmd(pbts_pkg::FUNC_CREATE, 4'hf, 8'd255);
    send_cmd(pbts_pkg::FUNC_CREATE, 4'h5, 8'd32);
    send_cmd(pbts_pkg::FUNC_CREATE, 4'h6, 8'd31);
    send_cmd(pbts_pkg::FUNC_CREATE, 4'h0, 8'd7);
    send_cmd(pbts_pkg::FUNC_RESUME, 4'h6, 0);
    send_cmd(pbts_pkg::FUNC_UNLOCK, 0, 0);
    send_cmd(pbts_pkg::FUNC_SELECT, 0, 0);
    send_cmd(pbts_pkg::FUNC_SELECT, 0, 0);
    send_cmd(pbts_pkg::FUNC_SUSPEND, 4'h0, 0);
    send_cmd(pbts_pkg::FUNC_SUSPEND, 4'h0, 0);
    send_cmd(pbts_pkg::FUNC_RESUME, 4'h0, 0);
    send_cmd(3'd6, 4'h3, 8'haa);
    send_cmd(3'd7, 4'hc, 8'h55);
    // lock depth saturation and back to zero
    for (int i = 0; i < 257; i++) send_cmd(pbts_pkg::FUNC_LOCK, 0, 0);
    for (int i = 0; i < 257; i++) send_cmd(pbts_pkg::FUNC_UNLOCK, 0, 0);

    // random phases, slicing toggled between them
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      write_slicing(ph[0]);
      for (int i = 0; i < 100; i++) begin
        k = $urandom_range(99);
        if (k < 18) f = pbts_pkg::FUNC_CREATE;
        else if (k < 33) f = pbts_pkg::FUNC_RESUME;
        else if (k < 50) f = pbts_pkg::FUNC_SUSPEND;
        else if (k < 76) f = pbts_pkg::FUNC_SELECT;
        else if (k < 86) f = pbts_pkg::FUNC_LOCK;
        else if (k < 97) f = pbts_pkg::FUNC_UNLOCK;
        else f = 3'($urandom_range(7, 6));
        pr = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(4));
        send_cmd(f, 4'($urandom_range(15)), pr);
      end
    end
    drain();

    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
